[hdl/rrf_pkg.sv]
package rrf_pkg;

  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int QUEUE_DEPTH     = 4;
  localparam int APB_ADDR_BITS   = 5;

  // floor(x / 3) = (x * DIV3_MUL) >> DIV3_SHIFT for x < 2**19
  localparam int DIV3_MUL      = 349526;
  localparam int DIV3_MUL_BITS = 19;
  localparam int DIV3_SHIFT    = 20;

  localparam logic [15:0] MAX_LEVEL_RST = 16'd255;
  localparam logic [10:0] ROW_WIDTH_RST = 11'd1024;

  typedef enum logic [2:0] {
    REG_MAX_LEVEL = 3'd0,
    REG_ROW_WIDTH = 3'd1,
    REG_GREY      = 3'd2,
    REG_MIRROR    = 3'd3,
    REG_INVERT    = 3'd4,
    REG_ZERO      = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [15:0] max_level;
    logic [10:0] row_width;
    logic        grey_enable;
    logic        mirror_enable;
    logic [2:0]  invert_mask;
    logic [2:0]  zero_mask;
  } cfg_t;

  typedef struct packed {
    logic has_result;
    logic use_mem;
    logic wr;
    logic last;
  } ctrl_t;

endpackage

[hdl/rrf_front.sv]
module rrf_front #(
  parameter int MAX_WIDTH   = rrf_pkg::MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = rrf_pkg::SAMPLE_BITS_DEF,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int AW = CW + 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  rrf_pkg::cfg_t            cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     action,
  input  logic [15:0]              red_in,
  input  logic [15:0]              green_in,
  input  logic [15:0]              blue_in,
  output logic                     push,
  input  logic                     full,
  output rrf_pkg::ctrl_t           push_ctrl,
  output logic [AW-1:0]            push_waddr,
  output logic [AW-1:0]            push_raddr,
  output logic [3*SAMPLE_BITS-1:0] push_px
);

  localparam int WW = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
  localparam int SB = SAMPLE_BITS;

  logic [CW-1:0] col, col_next;
  logic          bank, bank_next;
  logic          prev, prev_next;

  logic [WW-1:0] rw_ext, eff_w, col_ext;
  logic          row_end;
  logic [CW-1:0] rev, col_adv;
  logic          accept;

  always_comb begin
    rw_ext = WW'(cfg.row_width);
    if (rw_ext == '0) begin
      eff_w = WW'(1);
    end else if (rw_ext > WW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = rw_ext;
    end
    col_ext = WW'(col);
    row_end = (col_ext + WW'(1)) >= eff_w;
    rev     = (col_ext < eff_w) ? CW'(eff_w - WW'(1) - col_ext) : '0;
    col_adv = row_end ? '0 : col + CW'(1);
  end

  assign in_ready   = !full;
  assign accept     = in_valid && in_ready;
  assign push_waddr = {bank, col};
  assign push_raddr = {~bank, rev};
  assign push_px    = {blue_in[SB-1:0], green_in[SB-1:0], red_in[SB-1:0]};

  always_comb begin
    push      = 1'b0;
    push_ctrl = '0;
    col_next  = col;
    bank_next = bank;
    prev_next = prev;
    if (accept) begin
      if (action) begin
        if (cfg.mirror_enable && prev) begin
          push                 = 1'b1;
          push_ctrl.has_result = 1'b1;
          push_ctrl.use_mem    = 1'b1;
          push_ctrl.last       = row_end;
          col_next             = col_adv;
          if (row_end) begin
            prev_next = 1'b0;
          end
        end
      end else if (!cfg.mirror_enable) begin
        push                 = 1'b1;
        push_ctrl.has_result = 1'b1;
        push_ctrl.last       = row_end;
        col_next             = col_adv;
      end else begin
        push                 = 1'b1;
        push_ctrl.has_result = prev;
        push_ctrl.use_mem    = 1'b1;
        push_ctrl.wr         = 1'b1;
        push_ctrl.last       = row_end;
        col_next             = col_adv;
        if (row_end) begin
          bank_next = ~bank;
          prev_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      bank <= 1'b0;
      prev <= 1'b0;
    end else begin
      col  <= col_next;
      bank <= bank_next;
      prev <= prev_next;
    end
  end

endmodule

[hdl/rrf_queue.sv]
module rrf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = rrf_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] dout
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot [0:DEPTH-1];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [NW-1:0]    count;
  logic             do_push, do_pop;

  assign full    = count == NW'(DEPTH);
  assign valid   = count != '0;
  assign dout    = slot[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + NW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - NW'(1);
      end
    end
  end

endmodule

[hdl/rrf_back.sv]
module rrf_back #(
  parameter int MAX_WIDTH   = rrf_pkg::MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = rrf_pkg::SAMPLE_BITS_DEF,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int AW = CW + 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  rrf_pkg::cfg_t            cfg,
  input  logic                     q_valid,
  output logic                     q_pop,
  input  rrf_pkg::ctrl_t           q_ctrl,
  input  logic [AW-1:0]            q_waddr,
  input  logic [AW-1:0]            q_raddr,
  input  logic [3*SAMPLE_BITS-1:0] q_px,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [15:0]              red_out,
  output logic [15:0]              green_out,
  output logic [15:0]              blue_out,
  output logic                     row_last
);

  localparam int SB    = SAMPLE_BITS;
  localparam int PXW   = 3 * SB;
  localparam int SUMW  = SB + 2;
  localparam int PRODW = SUMW + rrf_pkg::DIV3_MUL_BITS;
  localparam logic [SB-1:0] SMASK = {SB{1'b1}};

  logic en;

  logic           v1, v2, v3;
  rrf_pkg::ctrl_t ctrl1, ctrl2, ctrl3;
  logic [AW-1:0]  waddr1, raddr1, waddr2, raddr2;
  logic [PXW-1:0] px1, px2, px3, px2_d, rd_data, sel;
  logic [PRODW-1:0] prod1;
  logic [SUMW-1:0]  sum;
  logic [SB-1:0]    top, avg;
  logic [SB-1:0]    ch [0:2];

  logic [PXW-1:0] mem [0:(2**AW)-1];

  assign top = (cfg.max_level > 16'(SMASK)) ? SMASK : cfg.max_level[SB-1:0];
  assign en  = !out_valid || out_ready;
  assign q_pop = en && q_valid;

  // stage 1: sum and reciprocal multiply for the grey average
  assign sum = SUMW'(q_px[0 +: SB]) + SUMW'(q_px[SB +: SB]) + SUMW'(q_px[2*SB +: SB]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl1  <= q_ctrl;
      waddr1 <= q_waddr;
      raddr1 <= q_raddr;
      px1    <= q_px;
      prod1  <= PRODW'(sum) * PRODW'(rrf_pkg::DIV3_MUL);
    end
  end

  // stage 2: grey, negate, flatten, clamp
  always_comb begin
    avg = prod1[rrf_pkg::DIV3_SHIFT +: SB];
    if (avg > top) begin
      avg = top;
    end
    for (int k = 0; k < 3; k++) begin
      ch[k] = cfg.grey_enable ? avg : px1[k*SB +: SB];
      if (cfg.invert_mask[k]) begin
        ch[k] = (ch[k] > top) ? '0 : top - ch[k];
      end
      if (cfg.zero_mask[k]) begin
        ch[k] = '0;
      end
      if (ch[k] > top) begin
        ch[k] = top;
      end
      px2_d[k*SB +: SB] = ch[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl2  <= ctrl1;
      waddr2 <= waddr1;
      raddr2 <= raddr1;
      px2    <= px2_d;
    end
  end

  // stage 3: line store write and read, result register
  always_ff @(posedge clk) begin
    if (en && v2 && ctrl2.wr) begin
      mem[waddr2] <= px2;
    end
    if (en) begin
      rd_data <= mem[raddr2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl3 <= ctrl2;
      px3   <= px2;
    end
  end

  assign out_valid = v3 && ctrl3.has_result;
  assign sel       = ctrl3.use_mem ? rd_data : px3;
  assign red_out   = 16'(sel[0 +: SB]);
  assign green_out = 16'(sel[SB +: SB]);
  assign blue_out  = 16'(sel[2*SB +: SB]);
  assign row_last  = ctrl3.last;

`ifndef SYNTH
  a_wr_needs_mirror: assert property (@(posedge clk) disable iff (rst)
    (v2 && ctrl2.wr) |-> (cfg.mirror_enable && ctrl2.use_mem))
    else $error("line store write without mirroring");

  a_direct_result: assert property (@(posedge clk) disable iff (rst)
    (v3 && ctrl3.has_result && !ctrl3.use_mem) |-> !cfg.mirror_enable)
    else $error("direct result while mirroring");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(v1) && $stable(v2) && (!v2 || $stable(ctrl2))))
    else $error("pipeline moved during output stall");
`endif

endmodule

[hdl/rgb_row_filter_with_mirror_top.sv]
// channel  handshake                 payload
// in       in_valid / in_ready       action, red_in, green_in, blue_in
// out      out_valid / out_ready     red_out, green_out, blue_out, row_last
// cfg      psel penable pwrite       paddr, pwdata, prdata (pready tied high)
//
// One item per cycle sustained while the output is not stalled; a result leaves the output
// register after its item passes through the queue and the back stages.
// The line store is read for every item and written for each pixel taken while mirroring, in the last back stage.
// A short queue parts the front from the back; the back halts while a result waits.
// Synchronous reset clears control state and config registers, not the line store or data.
module rgb_row_filter_with_mirror_top #(
  parameter int MAX_WIDTH   = rrf_pkg::MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = rrf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rrf_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              action,
  input  logic [15:0]                       red_in,
  input  logic [15:0]                       green_in,
  input  logic [15:0]                       blue_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [15:0]                       red_out,
  output logic [15:0]                       green_out,
  output logic [15:0]                       blue_out,
  output logic                              row_last
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int AW  = CW + 1;
  localparam int PXW = 3 * SAMPLE_BITS;
  localparam int QW  = $bits(rrf_pkg::ctrl_t) + 2 * AW + PXW;

  rrf_pkg::cfg_t       cfg;
  rrf_pkg::reg_index_t reg_idx;
  logic                wr_en;

  assign pready  = 1'b1;
  assign reg_idx = rrf_pkg::reg_index_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_level     <= rrf_pkg::MAX_LEVEL_RST;
      cfg.row_width     <= rrf_pkg::ROW_WIDTH_RST;
      cfg.grey_enable   <= 1'b0;
      cfg.mirror_enable <= 1'b0;
      cfg.invert_mask   <= '0;
      cfg.zero_mask     <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        rrf_pkg::REG_MAX_LEVEL: cfg.max_level     <= pwdata[15:0];
        rrf_pkg::REG_ROW_WIDTH: cfg.row_width     <= pwdata[10:0];
        rrf_pkg::REG_GREY:      cfg.grey_enable   <= pwdata[0];
        rrf_pkg::REG_MIRROR:    cfg.mirror_enable <= pwdata[0];
        rrf_pkg::REG_INVERT:    cfg.invert_mask   <= pwdata[2:0];
        rrf_pkg::REG_ZERO:      cfg.zero_mask     <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rrf_pkg::REG_MAX_LEVEL: prdata = 32'(cfg.max_level);
      rrf_pkg::REG_ROW_WIDTH: prdata = 32'(cfg.row_width);
      rrf_pkg::REG_GREY:      prdata = 32'(cfg.grey_enable);
      rrf_pkg::REG_MIRROR:    prdata = 32'(cfg.mirror_enable);
      rrf_pkg::REG_INVERT:    prdata = 32'(cfg.invert_mask);
      rrf_pkg::REG_ZERO:      prdata = 32'(cfg.zero_mask);
      default:                prdata = '0;
    endcase
  end

  logic           push, full, q_valid, q_pop;
  rrf_pkg::ctrl_t push_ctrl, q_ctrl;
  logic [AW-1:0]  push_waddr, push_raddr, q_waddr, q_raddr;
  logic [PXW-1:0] push_px, q_px;
  logic [QW-1:0]  q_din, q_dout;

  rrf_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .red_in     (red_in),
    .green_in   (green_in),
    .blue_in    (blue_in),
    .push       (push),
    .full       (full),
    .push_ctrl  (push_ctrl),
    .push_waddr (push_waddr),
    .push_raddr (push_raddr),
    .push_px    (push_px)
  );

  assign q_din = {push_ctrl, push_waddr, push_raddr, push_px};
  assign {q_ctrl, q_waddr, q_raddr, q_px} = q_dout;

  rrf_queue #(
    .WIDTH (QW),
    .DEPTH (rrf_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (q_din),
    .full  (full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_dout)
  );

  rrf_back #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_ctrl    (q_ctrl),
    .q_waddr   (q_waddr),
    .q_raddr   (q_raddr),
    .q_px      (q_px),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .row_last  (row_last)
  );

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

localparam bit ACT_PIXEL = 1'b0;
localparam bit ACT_DRAIN = 1'b1;
localparam int LINE_DEPTH = rrf_pkg::MAX_WIDTH_DEF;

typedef struct packed {
  logic [15:0] red;
  logic [15:0] green;
  logic [15:0] blue;
  logic        last;
} pixel_t;

class rgb_scoreboard;
  rrf_pkg::cfg_t cfg;
  pixel_t        line_mem [0:2*LINE_DEPTH-1];
  int unsigned   col;
  bit            bank;
  bit            prev_ready;
  pixel_t        expected_q[$];
  int            errors;

  function new();
    cfg.max_level = rrf_pkg::MAX_LEVEL_RST;
    cfg.row_width = rrf_pkg::ROW_WIDTH_RST;
    cfg.grey_enable = 1'b0;
    cfg.mirror_enable = 1'b0;
    cfg.invert_mask = 3'd0;
    cfg.zero_mask = 3'd0;
    col = 0;
    bank = 1'b0;
    prev_ready = 1'b0;
    errors = 0;
  endfunction

  function void write_reg(rrf_pkg::reg_index_t idx, logic [31:0] v);
    case (idx)
      rrf_pkg::REG_MAX_LEVEL: cfg.max_level = v[15:0];
      rrf_pkg::REG_ROW_WIDTH: cfg.row_width = v[10:0];
      rrf_pkg::REG_GREY:      cfg.grey_enable = v[0];
      rrf_pkg::REG_MIRROR:    cfg.mirror_enable = v[0];
      rrf_pkg::REG_INVERT:    cfg.invert_mask = v[2:0];
      rrf_pkg::REG_ZERO:      cfg.zero_mask = v[2:0];
      default: ;
    endcase
  endfunction

  function int unsigned row_len();
    if (cfg.row_width == 0) return 1;
    if (cfg.row_width > LINE_DEPTH) return LINE_DEPTH;
    return cfg.row_width;
  endfunction

  function pixel_t filter(logic [15:0] r, logic [15:0] g, logic [15:0] b);
    int unsigned top;
    int unsigned avg;
    int unsigned ch [3];
    int k;
    pixel_t p;
    top = cfg.max_level;
    ch[0] = r;
    ch[1] = g;
    ch[2] = b;
    if (cfg.grey_enable) begin
      avg = (ch[0] + ch[1] + ch[2]) / 3;
      if (avg > top) avg = top;
      for (k = 0; k < 3; k++) ch[k] = avg;
    end
    for (k = 0; k < 3; k++) begin
      if (cfg.invert_mask[k]) ch[k] = (ch[k] > top) ? 0 : top - ch[k];
      if (cfg.zero_mask[k]) ch[k] = 0;
      if (ch[k] > top) ch[k] = top;
    end
    p.red = 16'(ch[0]);
    p.green = 16'(ch[1]);
    p.blue = 16'(ch[2]);
    p.last = 1'b0;
    return p;
  endfunction

  function void note_input(bit act, logic [15:0] r, logic [15:0] g, logic [15:0] b);
    int unsigned w;
    int unsigned rev;
    int unsigned rd;
    int unsigned wr;
    bit row_end;
    pixel_t p;
    w = row_len();
    row_end = (col + 1 >= w);
    rev = (col < w) ? w - 1 - col : 0;
    rd = (bank ? 0 : LINE_DEPTH) + rev % LINE_DEPTH;
    wr = (bank ? LINE_DEPTH : 0) + col % LINE_DEPTH;
    if (act == ACT_DRAIN) begin
      if (!cfg.mirror_enable || !prev_ready) return;
      p = line_mem[rd];
      p.last = row_end;
      expected_q.push_back(p);
      col = row_end ? 0 : col + 1;
      if (row_end) prev_ready = 1'b0;
      return;
    end
    if (!cfg.mirror_enable) begin
      p = filter(r, g, b);
      p.last = row_end;
      expected_q.push_back(p);
      col = row_end ? 0 : col + 1;
      return;
    end
    if (prev_ready) begin
      p = line_mem[rd];
      p.last = row_end;
      expected_q.push_back(p);
    end
    line_mem[wr] = filter(r, g, b);
    col = row_end ? 0 : col + 1;
    if (row_end) begin
      bank = !bank;
      prev_ready = 1'b1;
    end
  endfunction

  function void check_result(pixel_t got);
    pixel_t want;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("error: unexpected result %0d/%0d/%0d last %0b",
                 got.red, got.green, got.blue, got.last);
      return;
    end
    want = expected_q.pop_front();
    if (got.red !== want.red || got.green !== want.green ||
        got.blue !== want.blue || got.last !== want.last) begin
      errors++;
      if (errors <= 10)
        $display("error: expected %0d/%0d/%0d last %0b, got %0d/%0d/%0d last %0b",
                 want.red, want.green, want.blue, want.last,
                 got.red, got.green, got.blue, got.last);
    end
  endfunction
endclass

module testbench;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              psel = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite = 1'b0;
  logic [rrf_pkg::APB_ADDR_BITS-1:0] paddr = '0;
  logic [31:0]                       pwdata = '0;
  logic [31:0]                       prdata;
  logic                              pready;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic                              action = ACT_PIXEL;
  logic [15:0]                       red_in = '0;
  logic [15:0]                       green_in = '0;
  logic [15:0]                       blue_in = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [15:0]                       red_out;
  logic [15:0]                       green_out;
  logic [15:0]                       blue_out;
  logic                              row_last;

  rgb_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  pixel_t got;

  rgb_row_filter_with_mirror_top uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .action(action),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .red_out(red_out), .green_out(green_out), .blue_out(blue_out),
    .row_last(row_last)
  );

  always #4 clk = ~clk;

  // result side: check accepted items, then pick next ready
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        got.red = red_out;
        got.green = green_out;
        got.blue = blue_out;
        got.last = row_last;
        sb.check_result(got);
      end
      if (hold_served < hold_requests) begin
        hold_served++;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic logic [15:0] rand_sample();
    logic [15:0] top;
    top = sb.cfg.max_level;
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return top;
      3: return top + 16'd1;
      4: return top - 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic rrf_pkg::cfg_t make_cfg(int unsigned lvl, int unsigned width, bit grey,
                                             bit mirror, logic [2:0] inv, logic [2:0] zro);
    rrf_pkg::cfg_t c;
    c.max_level = 16'(lvl);
    c.row_width = 11'(width);
    c.grey_enable = grey;
    c.mirror_enable = mirror;
    c.invert_mask = inv;
    c.zero_mask = zro;
    return c;
  endfunction

  function automatic rrf_pkg::cfg_t pick_cfg(int p);
    int unsigned lvl;
    int unsigned width;
    case (p)
      0: return make_cfg(65535, 1, 1'b0, 1'b1, 3'd7, 3'd0);
      1: return make_cfg(1, 3, 1'b1, 1'b1, 3'd5, 3'd2);
      2: return make_cfg(65535, 0, 1'b1, 1'b0, 3'd7, 3'd0);
      3: return make_cfg(1000, 2047, 1'b0, 1'b0, 3'd2, 3'd1);
      4: return make_cfg(255, 5, 1'b0, 1'b0, 3'd1, 3'd0);
      default: begin
        case ($urandom_range(3))
          0: lvl = 1;
          1: lvl = 65535;
          2: lvl = 255;
          default: lvl = $urandom_range(1, 65535);
        endcase
        width = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 8);
        return make_cfg(lvl, width, 1'($urandom_range(1)), ($urandom_range(2) != 0),
                        3'($urandom_range(7)),
                        $urandom_range(1) ? 3'd0 : 3'($urandom_range(7)));
      end
    endcase
  endfunction

  task automatic send_item(bit act, logic [15:0] r, logic [15:0] g, logic [15:0] b);
    in_valid <= 1'b1;
    action <= act;
    red_in <= r;
    green_in <= g;
    blue_in <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(act, r, g, b);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
  endtask

  task automatic send_pixel();
    send_item(ACT_PIXEL, rand_sample(), rand_sample(), rand_sample());
  endtask

  task automatic drain_row();
    int n;
    n = sb.row_len();
    repeat (n) send_item(ACT_DRAIN, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic wait_results();
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(rrf_pkg::reg_index_t idx, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  // leave mirroring with no stored row and column zero, so no stale entry is read
  task automatic settle_rows(bit next_mirror);
    if (sb.cfg.mirror_enable) begin
      while (sb.col != 0) send_pixel();
      if (sb.prev_ready) drain_row();
    end else if (next_mirror && sb.col != 0) begin
      // a one-pixel row brings the column back to zero
      in_valid <= 1'b0;
      wait_results();
      repeat (16) @(posedge clk);
      apb_write(rrf_pkg::REG_ROW_WIDTH, 32'd1);
      psel <= 1'b0;
      penable <= 1'b0;
      send_pixel();
    end
  endtask

  task automatic reconfigure(rrf_pkg::cfg_t c);
    settle_rows(c.mirror_enable);
    in_valid <= 1'b0;
    wait_results();
    repeat (16) @(posedge clk);
    apb_write(rrf_pkg::REG_MAX_LEVEL, 32'(c.max_level));
    apb_write(rrf_pkg::REG_ROW_WIDTH, 32'(c.row_width));
    apb_write(rrf_pkg::REG_GREY, 32'(c.grey_enable));
    apb_write(rrf_pkg::REG_MIRROR, 32'(c.mirror_enable));
    apb_write(rrf_pkg::REG_INVERT, 32'(c.invert_mask));
    apb_write(rrf_pkg::REG_ZERO, 32'(c.zero_mask));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_random(int n, bit pause_mid);
    int done;
    int pick;
    bit paused;
    done = 0;
    paused = 1'b0;
    while (done < n) begin
      if (pause_mid && !paused && done >= n / 2) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        wait_results();
      end
      pick = $urandom_range(99);
      if (sb.cfg.mirror_enable && sb.prev_ready && sb.col == 0 && pick < 12) begin
        done += sb.row_len();
        drain_row();
      end else if (pick >= 92 && !(sb.cfg.mirror_enable && sb.prev_ready)) begin
        send_item(ACT_DRAIN, 16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        send_pixel();
        done++;
      end
    end
  endtask

  initial begin
    int p;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_item(ACT_PIXEL, 16'd0, 16'd0, 16'd0);
    send_item(ACT_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(ACT_PIXEL, 16'd255, 16'd256, 16'd254);
    send_item(ACT_DRAIN, 16'd1, 16'd2, 16'd3);
    send_item(ACT_PIXEL, 16'd1, 16'd2, 16'd3);

    reconfigure(make_cfg(300, 2, 1'b1, 1'b1, 3'd3, 3'd4));
    send_item(ACT_DRAIN, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(ACT_PIXEL, 16'hFFFF, 16'd0, 16'd0);
    send_item(ACT_PIXEL, 16'd1, 16'd1, 16'd2);
    send_item(ACT_PIXEL, 16'd0, 16'd0, 16'd0);
    send_item(ACT_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    drain_row();
    send_item(ACT_DRAIN, 16'd0, 16'd0, 16'd0);

    reconfigure(make_cfg(1000, 3, 1'b0, 1'b0, 3'd7, 3'd0));
    send_item(ACT_PIXEL, 16'd1001, 16'd1000, 16'd0);
    send_item(ACT_PIXEL, 16'hFFFF, 16'd999, 16'd1);

    for (p = 0; p < 11; p++) begin
      reconfigure(pick_cfg(p));
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 55; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 55; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      if (p == 4) hold_requests++;
      run_random(40, p % 3 == 1);
    end

    // a full-width row reaches the top of a line store bank
    reconfigure(make_cfg(65535, 1024, 1'b0, 1'b1, 3'd0, 3'd0));
    idle_pct = 25;
    stall_pct = 25;
    repeat (LINE_DEPTH) send_pixel();
    send_item(ACT_DRAIN, 16'($urandom), 16'($urandom), 16'($urandom));

    in_valid <= 1'b0;
    wait_results();
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("rgb_row_filter_with_mirror_top: match");
    else
      $display("rgb_row_filter_with_mirror_top: mismatch");
    $finish;
  end

  initial begin
    #4000000;
    $display("rgb_row_filter_with_mirror_top: mismatch");
    $finish;
  end
endmodule
